// ===== src/hpq_pkg.sv =====
// Shared types and constants for the binary min-heap priority queue.
// No dependencies; hpq_ctrl and the top level import this package.
package hpq_pkg;

   localparam int CAPACITY     = 64;
   localparam int ADDR_W       = $clog2(CAPACITY);
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int IDX_W        = ADDR_W + 2;
   localparam int COUNT_OUT_W  = 7;
   localparam int ENTRY_W      = 64;
   localparam int REQ_TDATA_W  = 64;
   localparam int RSP_FIELDS_W = 106;
   localparam int RSP_TDATA_W  = 112;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Priority in the upper half, payload in the lower half.
   typedef struct packed {
      logic signed [31:0] pri;
      logic [31:0]        val;
   } entry_type;

   // Declared MSB first so that removed_valid lands in bit 0.
   typedef struct packed {
      logic                   dropped;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   is_empty;
      logic signed [31:0]     head_priority;
      logic [31:0]            head_value;
      logic [31:0]            removed_value;
      logic                   removed_valid;
   } result_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } ram_cmd_type;

endpackage

// ===== src/hpq_ram.sv =====
// Heap storage: one write port, two read ports with registered read data.
// Generic; no package dependency.
module hpq_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== src/hpq_ctrl.sv =====
// Heap sequencer: accepts one request, sifts through the heap RAM level by level.
// Depends on hpq_pkg; drives the hpq_ram command struct.
module hpq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hpq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   output logic                            res_valid,
   input  logic                            res_ready,
   output hpq_pkg::result_type             res,
   output hpq_pkg::ram_cmd_type            ram_cmd,
   input  hpq_pkg::entry_type              rd_data_a,
   input  hpq_pkg::entry_type              rd_data_b,
   output logic [hpq_pkg::CNT_W-1:0]       count
);
   import hpq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_DN_LOAD, ST_DN_RD, ST_DN_CMP, ST_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   entry_type         cur_ff, cur_in;
   entry_type         head_ff, head_in;
   logic              rem_valid_ff, rem_valid_in;
   logic [31:0]       rem_value_ff, rem_value_in;
   logic              drop_ff, drop_in;

   entry_type         req_entry;
   logic [ADDR_W-1:0] up_addr;
   logic [IDX_W-1:0]  l_idx, r_idx, cnt_ext;
   logic              take_l, take_r;
   logic signed [31:0] best_pri;

   assign req_entry = req_tdata;
   assign up_addr   = (pos_ff - ADDR_W'(1)) >> 1;
   assign l_idx     = IDX_W'({pos_ff, 1'b1});
   assign r_idx     = l_idx + IDX_W'(1);
   assign cnt_ext   = IDX_W'(cnt_ff);
   assign take_l    = (l_idx < cnt_ext) && (rd_data_a.pri < cur_ff.pri);
   assign best_pri  = take_l ? rd_data_a.pri : cur_ff.pri;
   assign take_r    = (r_idx < cnt_ext) && (rd_data_b.pri < best_pri);

   assign req_tready = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_FIN);
   assign count      = cnt_ff;

   always_comb begin
      res.removed_valid = rem_valid_ff;
      res.removed_value = rem_value_ff;
      res.is_empty      = (cnt_ff == '0);
      res.head_value    = res.is_empty ? 32'd0 : head_ff.val;
      res.head_priority = res.is_empty ? -32'sd1 : head_ff.pri;
      res.entry_count   = COUNT_OUT_W'(cnt_ff);
      res.dropped       = drop_ff;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      rem_valid_in = rem_valid_ff;
      rem_value_in = rem_value_ff;
      drop_in      = drop_ff;
      ram_cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rem_valid_in = 1'b0;
               rem_value_in = 32'd0;
               drop_in      = 1'b0;
               if (req_tuser == KIND_INSERT) begin
                  if (cnt_ff == CNT_W'(CAPACITY)) begin
                     drop_in  = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     cur_in   = req_entry;
                     pos_in   = ADDR_W'(cnt_ff);
                     cnt_in   = cnt_ff + CNT_W'(1);
                     state_in = ST_UP_RD;
                  end
               end else if (cnt_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  rem_valid_in = 1'b1;
                  rem_value_in = head_ff.val;
                  cnt_in       = cnt_ff - CNT_W'(1);
                  pos_in       = '0;
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_FIN;
                  end else begin
                     // fetch the last entry; it restarts at the root
                     ram_cmd.rd_addr_a = ADDR_W'(cnt_ff - CNT_W'(1));
                     state_in          = ST_DN_LOAD;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               ram_cmd.wr_en   = 1'b1;
               ram_cmd.wr_addr = '0;
               ram_cmd.wr_data = cur_ff;
               state_in        = ST_FIN;
            end else begin
               ram_cmd.rd_addr_a = up_addr;
               state_in          = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = pos_ff;
            if (cur_ff.pri < rd_data_a.pri) begin
               // pull the parent down into the hole and climb
               ram_cmd.wr_data = rd_data_a;
               pos_in          = up_addr;
               state_in        = ST_UP_RD;
            end else begin
               ram_cmd.wr_data = cur_ff;
               state_in        = ST_FIN;
            end
         end
         ST_DN_LOAD: begin
            cur_in   = rd_data_a;
            state_in = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (l_idx >= cnt_ext) begin
               ram_cmd.wr_en   = 1'b1;
               ram_cmd.wr_addr = pos_ff;
               ram_cmd.wr_data = cur_ff;
               state_in        = ST_FIN;
            end else begin
               ram_cmd.rd_addr_a = l_idx[ADDR_W-1:0];
               ram_cmd.rd_addr_b = r_idx[ADDR_W-1:0];
               state_in          = ST_DN_CMP;
            end
         end
         ST_DN_CMP: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = pos_ff;
            if (take_r) begin
               ram_cmd.wr_data = rd_data_b;
               pos_in          = r_idx[ADDR_W-1:0];
               state_in        = ST_DN_RD;
            end else if (take_l) begin
               ram_cmd.wr_data = rd_data_a;
               pos_in          = l_idx[ADDR_W-1:0];
               state_in        = ST_DN_RD;
            end else begin
               ram_cmd.wr_data = cur_ff;
               state_in        = ST_FIN;
            end
         end
         ST_FIN: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Mirror every root write so the head is known without a read.
   always_comb begin
      head_in = head_ff;
      if (ram_cmd.wr_en && ram_cmd.wr_addr == '0) begin
         head_in = ram_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rem_valid_ff <= 1'b0;
         drop_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rem_valid_ff <= rem_valid_in;
         drop_ff      <= drop_in;
      end
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      head_ff      <= head_in;
      rem_value_ff <= rem_value_in;
   end

endmodule

// ===== src/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue, top level: heap RAM, sequencer, result register.
// Depends on hpq_pkg, hpq_ram and hpq_ctrl.
//
// Holds up to CAPACITY (value, priority) entries in a single RAM with two read
// ports; the lowest signed priority leaves first, with ties resolved as a
// classic array heap would (strict less-than, left child before right). Each
// request beat (tuser 0 insert, 1 remove) yields exactly one response beat
// carrying the removed entry, the new head, the empty flag, the count and a
// drop flag for an insert into a full heap. One request is in flight at a time;
// its handling is paced by the per-level read-compare-write loop on the heap
// RAM: one RAM read and one write back per heap level. The next request is
// taken while the previous response waits in the output register. The RAM
// needs no clearing after reset; only entries below the count are ever used.
module binary_min_heap_priority_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] value, [63:32] priority_req
   input  logic [hpq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] kind
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] removed_valid, [32:1] removed_value, [64:33] head_value,
   // [96:65] head_priority, [97] is_empty, [104:98] entry_count, [105] dropped
   output logic [hpq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import hpq_pkg::*;

   ram_cmd_type       ram_cmd;
   logic [ENTRY_W-1:0] rd_vec_a, rd_vec_b;
   entry_type         rd_data_a, rd_data_b;
   result_type        res;
   logic              res_valid, res_ready;
   logic [CNT_W-1:0]  count;

   result_type        rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign rd_data_a = rd_vec_a;
   assign rd_data_b = rd_vec_b;

   hpq_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W),
      .DATA_W (ENTRY_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_cmd.wr_en),
      .wr_addr   (ram_cmd.wr_addr),
      .wr_data   (ram_cmd.wr_data),
      .rd_addr_a (ram_cmd.rd_addr_a),
      .rd_addr_b (ram_cmd.rd_addr_b),
      .rd_data_a (rd_vec_a),
      .rd_data_b (rd_vec_b)
   );

   hpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .ram_cmd    (ram_cmd),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .count      (count)
   );

   // Load a new result when the output register is empty or draining.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), rsp_ff};

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while sequencer busy");

   a_wr_in_heap: assert property (@(posedge clock) disable iff (reset)
      ram_cmd.wr_en |-> (CNT_W'(ram_cmd.wr_addr) < count))
      else $error("heap write outside the filled region");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ff.is_empty == (rsp_ff.entry_count == '0)))
      else $error("empty flag disagrees with entry count");

endmodule
